[sv/rrc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrc_pkg
// Shared widths and lane types for the RGB565 channel RMS combiner.
// ----------------------------------------------------------------------------
package rrc_pkg;

	// pixel layout
	localparam int PIX_W   = 16;
	localparam int BLUE_W  = 5;
	localparam int GREEN_W = 6;
	localparam int RED_W   = 5;
	localparam int BLUE_LSB  = 0;
	localparam int GREEN_LSB = 5;
	localparam int RED_LSB   = 11;
	localparam int NUM_CH  = 3;

	// lane order inside a stage
	localparam int LANE_BLUE  = 0;
	localparam int LANE_GREEN = 1;
	localparam int LANE_RED   = 2;

	// widest channel sets the lane widths
	localparam int CH_W   = GREEN_W;
	localparam int RAD_W  = 2 * CH_W;
	localparam int ROOT_W = CH_W;
	localparam int REM_W  = ROOT_W + 2;

	// one channel in flight through the root chain
	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} rrc_lane_t;

	typedef rrc_lane_t [NUM_CH-1:0] rrc_stage_t;

endpackage

[sv/rrc_pair_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrc_pair_if
// Channel carrying one pair of RGB565 source pixels.
// ----------------------------------------------------------------------------
interface rrc_pair_if import rrc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_a;
	logic [PIX_W-1:0] pixel_b;

	modport source (output valid, output pixel_a, output pixel_b, input ready);
	modport sink   (input valid, input pixel_a, input pixel_b, output ready);
endinterface

[sv/rrc_pix_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrc_pix_if
// Channel carrying one combined RGB565 pixel.
// ----------------------------------------------------------------------------
interface rrc_pix_if import rrc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;

	modport source (output valid, output pixel_out, input ready);
	modport sink   (input valid, input pixel_out, output ready);
endinterface

[sv/rrc_mean.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrc_mean
// Front stage: splits both pixels into channels and registers the
// halved sum of squares of each channel as the radicand of its lane.
// ----------------------------------------------------------------------------
module rrc_mean import rrc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             in_valid,
	input  logic [PIX_W-1:0] pixel_a,
	input  logic [PIX_W-1:0] pixel_b,
	output logic             valid_s1,
	output rrc_stage_t       lanes_s1
);

	logic [CH_W-1:0]   ch_a [NUM_CH];
	logic [CH_W-1:0]   ch_b [NUM_CH];
	logic [RAD_W-1:0]  sq_a [NUM_CH];
	logic [RAD_W-1:0]  sq_b [NUM_CH];
	logic [RAD_W:0]    sum  [NUM_CH];
	rrc_stage_t        lanes_d;

	// channel split, narrow channels zero extended
	always_comb begin
		ch_a[LANE_BLUE]  = CH_W'(pixel_a[BLUE_LSB +: BLUE_W]);
		ch_b[LANE_BLUE]  = CH_W'(pixel_b[BLUE_LSB +: BLUE_W]);
		ch_a[LANE_GREEN] = CH_W'(pixel_a[GREEN_LSB +: GREEN_W]);
		ch_b[LANE_GREEN] = CH_W'(pixel_b[GREEN_LSB +: GREEN_W]);
		ch_a[LANE_RED]   = CH_W'(pixel_a[RED_LSB +: RED_W]);
		ch_b[LANE_RED]   = CH_W'(pixel_b[RED_LSB +: RED_W]);
	end

	// halved sum of squares per lane
	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			sq_a[i] = RAD_W'(ch_a[i]) * RAD_W'(ch_a[i]);
			sq_b[i] = RAD_W'(ch_b[i]) * RAD_W'(ch_b[i]);
			sum[i]  = (RAD_W+1)'(sq_a[i]) + (RAD_W+1)'(sq_b[i]);
			lanes_d[i].rad  = sum[i][RAD_W:1];
			lanes_d[i].rem  = '0;
			lanes_d[i].root = '0;
		end
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			lanes_s1 <= lanes_d;
		end
	end

	// a transfer always lands in the stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && in_valid) |=> valid_s1)
		else $error("accepted pair did not enter the mean stage");

endmodule

[sv/rrc_root_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrc_root_cell
// One cell of the square root chain: settles one root bit of every lane
// from the next two radicand bits and hands the lanes to the next cell.
// ----------------------------------------------------------------------------
module rrc_root_cell import rrc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic       in_valid,
	input  rrc_stage_t in_lanes,
	output logic       valid_q,
	output rrc_stage_t lanes_q
);

	logic [REM_W+1:0] cur   [NUM_CH];
	logic [REM_W+1:0] trial [NUM_CH];
	logic [REM_W+1:0] diff  [NUM_CH];
	rrc_stage_t       lanes_d;

	// restoring digit step per lane
	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			cur[i]   = {in_lanes[i].rem, in_lanes[i].rad[RAD_W-1 -: 2]};
			trial[i] = (REM_W+2)'({in_lanes[i].root, 2'b01});
			diff[i]  = cur[i] - trial[i];
			lanes_d[i].rad = {in_lanes[i].rad[RAD_W-3:0], 2'b00};
			if (cur[i] >= trial[i]) begin
				lanes_d[i].rem  = diff[i][REM_W-1:0];
				lanes_d[i].root = {in_lanes[i].root[ROOT_W-2:0], 1'b1};
			end else begin
				lanes_d[i].rem  = cur[i][REM_W-1:0];
				lanes_d[i].root = {in_lanes[i].root[ROOT_W-2:0], 1'b0};
			end
		end
	end

	// cell valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
		end
	end

	// cell payload
	always_ff @(posedge clk) begin
		if (adv) begin
			lanes_q <= lanes_d;
		end
	end

	// partial remainder never exceeds twice the partial root
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (lanes_q[LANE_GREEN].rem <= REM_W'({lanes_q[LANE_GREEN].root, 1'b0})))
		else $error("root cell remainder out of bound");

endmodule

[sv/rgb565_channel_rms_combine_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565_channel_rms_combine_core
// Per channel root mean square blend of two RGB565 pixels.
// ----------------------------------------------------------------------------
// Takes one pixel pair per clock unless the sink stalls, and returns one
// RGB565 pixel whose blue, green and red channels are each floor(sqrt(
// floor((a*a + b*b) / 2))) of the matching input channels. One stage forms
// the halved sum of squares, then a chain of six root cells settles one
// root bit per cell for all three channels at once. The last cell is the
// output register; when the sink stalls the whole chain holds, and
// pair.ready is low only while a finished pixel waits and blend.ready is low.
// ----------------------------------------------------------------------------
module rgb565_channel_rms_combine_core import rrc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	rrc_pair_if.sink  pair,
	rrc_pix_if.source blend
);

	logic       adv;
	logic       valid_s1;
	rrc_stage_t lanes_s1;
	logic       cell_valid [ROOT_W+1];
	rrc_stage_t cell_lanes [ROOT_W+1];

	// whole chain moves unless a finished pixel is stuck
	assign adv        = !blend.valid || blend.ready;
	assign pair.ready = adv;

	// mean stage
	rrc_mean u_mean (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (pair.valid),
		.pixel_a  (pair.pixel_a),
		.pixel_b  (pair.pixel_b),
		.valid_s1 (valid_s1),
		.lanes_s1 (lanes_s1)
	);

	assign cell_valid[0] = valid_s1;
	assign cell_lanes[0] = lanes_s1;

	// root chain, one bit per cell
	for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
		rrc_root_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.in_valid (cell_valid[k]),
			.in_lanes (cell_lanes[k]),
			.valid_q  (cell_valid[k+1]),
			.lanes_q  (cell_lanes[k+1])
		);
	end

	// pack roots back into RGB565
	assign blend.valid     = cell_valid[ROOT_W];
	assign blend.pixel_out = {cell_lanes[ROOT_W][LANE_RED].root[RED_W-1:0],
		cell_lanes[ROOT_W][LANE_GREEN].root[GREEN_W-1:0],
		cell_lanes[ROOT_W][LANE_BLUE].root[BLUE_W-1:0]};

	// narrow channels never grow a root beyond their width
	a_narrow_roots: assert property (@(posedge clk) disable iff (!arst_n)
		blend.valid |-> (cell_lanes[ROOT_W][LANE_BLUE].root[ROOT_W-1] == 1'b0 &&
		cell_lanes[ROOT_W][LANE_RED].root[ROOT_W-1] == 1'b0))
		else $error("blue or red root exceeds channel width");

	// all radicand bits consumed at the end of the chain
	a_rad_used: assert property (@(posedge clk) disable iff (!arst_n)
		blend.valid |-> (cell_lanes[ROOT_W][LANE_GREEN].rad == '0))
		else $error("radicand not fully consumed");

	// stalled chain keeps the result in place
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(cell_lanes[ROOT_W]))
		else $error("result changed during a stall");

endmodule
